// ----- sv/bhc_pkg.sv -----
`default_nettype none

package bhc_pkg;

  // Field widths
  localparam int unsigned CMP_W    = 16;
  localparam int unsigned HALL_W   = 3;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Duty scaling: compare = period * duty / 100, done as ((period * duty) >> 2) / 25,
  // with the divide by 25 as a multiply by a rounded-up reciprocal and a shift.
  localparam int unsigned PROD_W      = CMP_W + DUTY_W;          // period * duty
  localparam int unsigned QUART_W     = PROD_W - 2;              // product / 4
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RPROD_W     = QUART_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_25 = 20'd671089;          // ceil(2^24 / 25)
  localparam logic [DUTY_W-1:0]  DUTY_MAX = 7'd100;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_PERIOD   = 2'd0,
    REG_DUTY_PERCENT = 2'd1,
    REG_REVERSE_DIR  = 2'd2,
    REG_STALL_GUARD  = 2'd3
  } cfg_reg_e;

  // Item kinds
  typedef enum logic {
    ACT_TICK    = 1'b0,
    ACT_CAPTURE = 1'b1
  } action_e;

  // Bridge phase select, PH_NONE when no phase is driven
  typedef enum logic [1:0] {
    PH_U    = 2'd0,
    PH_V    = 2'd1,
    PH_W    = 2'd2,
    PH_NONE = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e hi;
    phase_e lo;
  } drive_sel_t;

  // Per-item control carried down the scaling pipeline
  typedef struct packed {
    logic       fault;
    logic       load;   // item brings a fresh compare value
    drive_sel_t sel;
  } item_ctl_t;

  // Six-step table: forward order, reverse swaps the high and low phases
  function automatic drive_sel_t hall_lookup(logic [HALL_W-1:0] hall, logic rev);
    drive_sel_t fwd;
    drive_sel_t res;
    unique case (hall)
      3'd1:    fwd = '{hi: PH_U, lo: PH_W};
      3'd2:    fwd = '{hi: PH_V, lo: PH_U};
      3'd3:    fwd = '{hi: PH_V, lo: PH_W};
      3'd4:    fwd = '{hi: PH_W, lo: PH_V};
      3'd5:    fwd = '{hi: PH_U, lo: PH_V};
      3'd6:    fwd = '{hi: PH_W, lo: PH_U};
      default: fwd = '{hi: PH_NONE, lo: PH_NONE};
    endcase
    if (rev) begin
      res = '{hi: fwd.lo, lo: fwd.hi};
    end else begin
      res = fwd;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/bhc_in_if.sv -----
`default_nettype none

interface bhc_in_if import bhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [HALL_W-1:0] hall_state;

  modport source (output valid, output action, output hall_state, input ready);
  modport sink   (input valid, input action, input hall_state, output ready);
endinterface

`default_nettype wire

// ----- sv/bhc_out_if.sv -----
`default_nettype none

interface bhc_out_if import bhc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMP_W-1:0] compare_u;
  logic [CMP_W-1:0] compare_v;
  logic [CMP_W-1:0] compare_w;
  logic             low_u_on;
  logic             low_v_on;
  logic             low_w_on;
  logic             stall_fault;

  modport source (
    output valid, output compare_u, output compare_v, output compare_w,
    output low_u_on, output low_v_on, output low_w_on, output stall_fault,
    input  ready
  );
  modport sink (
    input  valid, input compare_u, input compare_v, input compare_w,
    input  low_u_on, input low_v_on, input low_w_on, input stall_fault,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/bldc_hall_commutator.sv -----
`default_nettype none

// Six-step Hall commutator for a three-phase BLDC bridge with a stall guard.
// Each request is a PWM period tick or a Hall capture; every request yields
// one drive result (three high-side compares, three low-side enables and the
// latched stall fault). One request is taken per clock cycle unless the
// result side stalls; the high-side compare is scaled as period * duty / 100
// through a three-register chain (period-by-duty product, reciprocal multiply
// for the divide by 25, result register). The commutation state and stall
// counter update in the cycle a request is accepted. The input side keeps
// accepting while results wait, until all three stages hold results. Period,
// duty and direction take effect at the next Hall capture, the stall guard at
// the next tick; a stall fault forces all drive off until reset.
module bldc_hall_commutator import bhc_pkg::*; #(
  parameter int unsigned STALL_LIMIT = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  bhc_in_if.sink                    in_i,
  bhc_out_if.source                 out_o
);

  localparam int unsigned CntW = $clog2(STALL_LIMIT + 1);
  localparam logic [CntW-1:0] CntLimit = CntW'(STALL_LIMIT);

  // Configuration registers
  logic [CMP_W-1:0]  period_q;
  logic [DUTY_W-1:0] duty_q;
  logic              rev_q;
  logic              guard_q;

  // Commutation state
  logic [CntW-1:0]   stall_cnt_q, stall_cnt_d;
  logic              fault_q, fault_d;
  drive_sel_t        sel_q, sel_d;
  logic              load_d;

  // Pipeline stages
  logic              v1_q, v2_q, v3_q;
  item_ctl_t         ctl1_q, ctl2_q;
  logic [PROD_W-1:0] prod1_q;
  logic [CMP_W-1:0]  quot2_q;
  logic [CMP_W-1:0]  cmp_hold_q;
  logic              rdy1, rdy2, rdy3;
  logic              in_acc;

  logic [DUTY_W-1:0]  duty_sat;
  logic [QUART_W-1:0] quart;
  logic [RPROD_W-1:0] recip_prod;
  logic [CMP_W-1:0]   cmp_sel;
  drive_sel_t         look;

  logic [CMP_W-1:0]  cmp_u_q, cmp_v_q, cmp_w_q;
  logic              low_u_q, low_v_q, low_w_q, flt_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      duty_q   <= '0;
      rev_q    <= 1'b0;
      guard_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PWM_PERIOD:   period_q <= cfg_wdata_i[CMP_W-1:0];
        REG_DUTY_PERCENT: duty_q   <= cfg_wdata_i[DUTY_W-1:0];
        REG_REVERSE_DIR:  rev_q    <= cfg_wdata_i[0];
        REG_STALL_GUARD:  guard_q  <= cfg_wdata_i[0];
      endcase
    end
  end

  // Stage handshake: a stage moves when it is empty or the next one moves
  assign rdy3       = !v3_q || out_o.ready;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;
  assign in_acc     = in_i.valid && rdy1;

  // Apply one request to the commutation state
  always_comb begin
    stall_cnt_d = stall_cnt_q;
    fault_d     = fault_q;
    sel_d       = sel_q;
    load_d      = 1'b0;
    look        = hall_lookup(in_i.hall_state, rev_q);
    if (!fault_q) begin
      if (action_e'(in_i.action) == ACT_TICK) begin
        if (guard_q) begin
          if (stall_cnt_q >= CntLimit) begin
            fault_d     = 1'b1;
            stall_cnt_d = '0;
            sel_d       = '{hi: PH_NONE, lo: PH_NONE};
          end else begin
            stall_cnt_d = stall_cnt_q + 1'b1;
          end
        end
      end else begin
        stall_cnt_d = '0;
        if (look.hi != PH_NONE) begin
          sel_d  = look;
          load_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cnt_q <= '0;
      fault_q     <= 1'b0;
      sel_q       <= '{hi: PH_NONE, lo: PH_NONE};
    end else if (in_acc) begin
      stall_cnt_q <= stall_cnt_d;
      fault_q     <= fault_d;
      sel_q       <= sel_d;
    end
  end

  // Scale datapath: saturate duty, divide by 25 via reciprocal
  assign duty_sat   = (duty_q > DUTY_MAX) ? DUTY_MAX : duty_q;
  assign quart      = prod1_q[PROD_W-1:2];
  assign recip_prod = RPROD_W'(quart) * RPROD_W'(RECIP_25);
  assign cmp_sel    = ctl2_q.load ? quot2_q : cmp_hold_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Hold the compare of the last capture that drove a phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_hold_q <= '0;
    end else if (rdy3 && v2_q && ctl2_q.load) begin
      cmp_hold_q <= quot2_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ctl1_q  <= '{fault: fault_d, load: load_d, sel: sel_d};
      prod1_q <= PROD_W'(period_q) * PROD_W'(duty_sat);
    end
    if (rdy2) begin
      ctl2_q  <= ctl1_q;
      quot2_q <= recip_prod[RECIP_SHIFT +: CMP_W];
    end
    if (rdy3) begin
      cmp_u_q <= (!ctl2_q.fault && ctl2_q.sel.hi == PH_U) ? cmp_sel : '0;
      cmp_v_q <= (!ctl2_q.fault && ctl2_q.sel.hi == PH_V) ? cmp_sel : '0;
      cmp_w_q <= (!ctl2_q.fault && ctl2_q.sel.hi == PH_W) ? cmp_sel : '0;
      low_u_q <= !ctl2_q.fault && ctl2_q.sel.lo == PH_U;
      low_v_q <= !ctl2_q.fault && ctl2_q.sel.lo == PH_V;
      low_w_q <= !ctl2_q.fault && ctl2_q.sel.lo == PH_W;
      flt_q   <= ctl2_q.fault;
    end
  end

  // Drive result channel
  assign out_o.valid       = v3_q;
  assign out_o.compare_u   = cmp_u_q;
  assign out_o.compare_v   = cmp_v_q;
  assign out_o.compare_w   = cmp_w_q;
  assign out_o.low_u_on    = low_u_q;
  assign out_o.low_v_on    = low_v_q;
  assign out_o.low_w_on    = low_w_q;
  assign out_o.stall_fault = flt_q;

  // A latched fault never clears
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q)
    else $error("stall fault cleared without reset");

  // The stall counter stays within the limit
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_cnt_q <= CntLimit)
    else $error("stall counter beyond limit");

  // A faulted result carries no drive
  a_fault_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.stall_fault) |->
      (out_o.compare_u == '0 && out_o.compare_v == '0 && out_o.compare_w == '0 &&
       !out_o.low_u_on && !out_o.low_v_on && !out_o.low_w_on))
    else $error("drive present while faulted");

  // At most one low side is on, and no phase has both its low side and a compare on
  a_one_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($onehot0({out_o.low_u_on, out_o.low_v_on, out_o.low_w_on}) &&
      !(out_o.low_u_on && out_o.compare_u != '0) &&
      !(out_o.low_v_on && out_o.compare_v != '0) &&
      !(out_o.low_w_on && out_o.compare_w != '0)))
    else $error("shoot-through drive pattern");

endmodule

`default_nettype wire

// ----- verif/bldc_hall_commutator_tb.sv -----
`timescale 1ns / 1ps

module bldc_hall_commutator_tb import bhc_pkg::*; ();

  localparam int unsigned STALL_LIMIT = 5;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASES      = 16;
  localparam int unsigned PHASE_ITEMS = 120;
  localparam int unsigned AFTER_FAULT = 40;

  // One drive result as the block reports it
  typedef struct packed {
    logic [CMP_W-1:0] cmp_u;
    logic [CMP_W-1:0] cmp_v;
    logic [CMP_W-1:0] cmp_w;
    logic             low_u;
    logic             low_v;
    logic             low_w;
    logic             fault;
  } drive_t;

  // Directed step: a register write or a request, with an optional fixed result
  typedef struct packed {
    logic              is_cfg;
    cfg_reg_e          idx;
    logic [CFG_W-1:0]  wdata;
    action_e           act;
    logic [HALL_W-1:0] hall;
    logic              has_exp;
    drive_t            exp;
  } dir_row_t;

  typedef struct packed {
    logic   has;
    drive_t val;
  } fixed_t;

  localparam drive_t DRV_OFF    = '{16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam drive_t DRV_UW_0   = '{16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam drive_t DRV_UW_MAX = '{16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam drive_t DRV_VU_MAX = '{16'd0, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam drive_t DRV_FAULT  = '{16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1};

  // Forward six-step table; reverse swaps high and low
  localparam phase_e FWD_HI [8] = '{PH_NONE, PH_U, PH_V, PH_V, PH_W, PH_U, PH_W, PH_NONE};
  localparam phase_e FWD_LO [8] = '{PH_NONE, PH_W, PH_U, PH_W, PH_V, PH_V, PH_U, PH_NONE};

  // Hall states in rotor order for the forward table
  localparam logic [HALL_W-1:0] ROTATION [6] = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4};

  localparam int unsigned HEAD_N = 34;
  localparam int unsigned DIR_N  = 46;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // reset state, then period and duty still zero
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd0, 1'b1, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd1, 1'b1, DRV_UW_0},
    // full scale
    '{1'b1, REG_PWM_PERIOD,   16'hFFFF, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b1, REG_DUTY_PERCENT, 16'd100,  ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd1, 1'b1, DRV_UW_MAX},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd2, 1'b1, DRV_VU_MAX},
    // duty above 100 saturates; hall 0 and 7 keep the drive
    '{1'b1, REG_DUTY_PERCENT, 16'h007F, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd0, 1'b1, DRV_VU_MAX},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd7, 1'b1, DRV_VU_MAX},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd1, 1'b1, DRV_UW_MAX},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd7, 1'b1, DRV_UW_MAX},
    // mid-scale, upper write bits set, rest of the forward table
    '{1'b1, REG_DUTY_PERCENT, 16'hFFB2, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b1, REG_PWM_PERIOD,   16'd12345, ACT_TICK,   3'd0, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd3, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd4, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd5, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd6, 1'b0, DRV_OFF},
    // reverse table
    '{1'b1, REG_REVERSE_DIR,  16'hFFFF, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd1, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd2, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd3, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd4, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd5, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd6, 1'b0, DRV_OFF},
    // stall guard: reach the limit, then a capture clears it
    '{1'b1, REG_STALL_GUARD,  16'h0001, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd7, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd2, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd5, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd1, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd2, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd6, 1'b0, DRV_OFF},
    '{1'b1, REG_REVERSE_DIR,  16'h0000, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b1, REG_STALL_GUARD,  16'h0000, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    // closing rows: let the stall fault latch, then it masks everything
    '{1'b1, REG_STALL_GUARD,  16'hFFFF, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b1, REG_PWM_PERIOD,   16'hFFFF, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b1, REG_DUTY_PERCENT, 16'd1,    ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd4, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd0, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd3, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd4, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd7, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd1, 1'b0, DRV_OFF},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd5, 1'b1, DRV_FAULT},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_CAPTURE, 3'd1, 1'b1, DRV_FAULT},
    '{1'b0, REG_PWM_PERIOD,   16'h0000, ACT_TICK,    3'd0, 1'b1, DRV_FAULT}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  bhc_in_if  in_if ();
  bhc_out_if out_if ();

  bldc_hall_commutator #(
    .STALL_LIMIT(STALL_LIMIT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers
  logic [CMP_W-1:0]  pr_period;
  logic [DUTY_W-1:0] pr_duty;
  logic              pr_rev;
  logic              pr_guard;
  logic [2:0]        pr_stall;
  logic              pr_fault;
  logic [CMP_W-1:0]  pr_cmp [3];
  logic              pr_low [3];

  drive_t drive_exp_q [$];
  fixed_t fixed_drive_q [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 12;
  int unsigned hold_reqs = 0;
  bit          bus_busy = 1'b0;

  // Apply one request to the predicted drive and return the reported result
  function automatic drive_t commutate(action_e act, logic [HALL_W-1:0] hall);
    phase_e      hi;
    phase_e      lo;
    int unsigned duty_sat;
    int unsigned prod;
    drive_t      res;
    if (!pr_fault) begin
      if (act == ACT_TICK) begin
        if (pr_guard) begin
          if (pr_stall >= STALL_LIMIT) begin
            pr_fault = 1'b1;
            pr_stall = '0;
            for (int i = 0; i < 3; i++) begin
              pr_cmp[i] = '0;
              pr_low[i] = 1'b0;
            end
          end else begin
            pr_stall = pr_stall + 3'd1;
          end
        end
      end else begin
        pr_stall = '0;
        hi = pr_rev ? FWD_LO[hall] : FWD_HI[hall];
        lo = pr_rev ? FWD_HI[hall] : FWD_LO[hall];
        if (hi != PH_NONE && lo != PH_NONE) begin
          duty_sat = (pr_duty > 7'd100) ? 100 : int'(unsigned'(32'(pr_duty)));
          prod = 32'(pr_period) * duty_sat;
          for (int i = 0; i < 3; i++) begin
            pr_cmp[i] = '0;
            pr_low[i] = 1'b0;
          end
          pr_cmp[hi] = CMP_W'(prod / 100);
          pr_low[lo] = 1'b1;
        end
      end
    end
    res.cmp_u = pr_fault ? '0 : pr_cmp[0];
    res.cmp_v = pr_fault ? '0 : pr_cmp[1];
    res.cmp_w = pr_fault ? '0 : pr_cmp[2];
    res.low_u = pr_fault ? 1'b0 : pr_low[0];
    res.low_v = pr_fault ? 1'b0 : pr_low[1];
    res.low_w = pr_fault ? 1'b0 : pr_low[2];
    res.fault = pr_fault;
    return res;
  endfunction

  // Predict on every accepted request
  always @(posedge clk_i) begin
    drive_t want;
    fixed_t fixed;
    if (rst_ni && in_if.valid && in_if.ready) begin
      want = commutate(action_e'(in_if.action), in_if.hall_state);
      fixed = (fixed_drive_q.size() != 0) ? fixed_drive_q.pop_front() : '0;
      drive_exp_q.push_back(fixed.has ? fixed.val : want);
    end
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    drive_t got;
    drive_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.compare_u, out_if.compare_v, out_if.compare_w,
              out_if.low_u_on, out_if.low_v_on, out_if.low_w_on, out_if.stall_fault};
      if (drive_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected drive result %h", got);
        end
      end else begin
        want = drive_exp_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("drive mismatch: exp cmp %h %h %h low %b%b%b fault %b",
                     want.cmp_u, want.cmp_v, want.cmp_w,
                     want.low_u, want.low_v, want.low_w, want.fault);
            $display("                got cmp %h %h %h low %b%b%b fault %b",
                     got.cmp_u, got.cmp_v, got.cmp_w,
                     got.low_u, got.low_v, got.low_w, got.fault);
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bldc_hall_commutator verification failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    if (bus_busy) begin
      in_if.valid <= 1'b0;
      bus_busy = 1'b0;
    end
    @(posedge clk_i);
    while (drive_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    unique case (idx)
      REG_PWM_PERIOD:   pr_period = data;
      REG_DUTY_PERCENT: pr_duty   = data[DUTY_W-1:0];
      REG_REVERSE_DIR:  pr_rev    = data[0];
      REG_STALL_GUARD:  pr_guard  = data[0];
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic offer(action_e act, logic [HALL_W-1:0] hall, fixed_t fixed);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    fixed_drive_q.push_back(fixed);
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.hall_state <= hall;
    bus_busy = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic run_rows(int unsigned first, int unsigned last);
    for (int unsigned i = first; i < last; i++) begin
      if (DIR_ROWS[i].is_cfg) begin
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].wdata);
      end else begin
        offer(DIR_ROWS[i].act, DIR_ROWS[i].hall, '{DIR_ROWS[i].has_exp, DIR_ROWS[i].exp});
      end
    end
  endtask

  initial begin
    int unsigned       gen_stall;
    int unsigned       pos;
    int unsigned       tick_pct;
    int unsigned       r;
    bit                fwd;
    action_e           act;
    logic [HALL_W-1:0] hall;

    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.action     = 1'b0;
    in_if.hall_state = '0;
    pr_period = '0;
    pr_duty   = '0;
    pr_rev    = 1'b0;
    pr_guard  = 1'b0;
    pr_stall  = '0;
    pr_fault  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pr_cmp[i] = '0;
      pr_low[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_rows(0, HEAD_N);

    // Random phases: new settings each time, then mostly rotating captures
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          write_reg(REG_PWM_PERIOD, 16'hFFFF);
          write_reg(REG_DUTY_PERCENT, ($urandom_range(1) != 0) ? 16'd100 : 16'd127);
        end
        1: begin
          write_reg(REG_PWM_PERIOD, 16'h0000);
          write_reg(REG_DUTY_PERCENT, 16'h0000);
        end
        default: begin
          write_reg(REG_PWM_PERIOD, CFG_W'($urandom_range(65535)));
          write_reg(REG_DUTY_PERCENT, CFG_W'($urandom_range(65535)));
        end
      endcase
      write_reg(REG_REVERSE_DIR, CFG_W'($urandom_range(65535)));
      write_reg(REG_STALL_GUARD, CFG_W'($urandom_range(65535)));

      gen_stall   = 32'(pr_stall);
      pos         = $urandom_range(5);
      fwd         = 1'($urandom_range(1));
      tick_pct    = pr_guard ? 45 : 30;
      tx_idle_pct = (p == 5) ? 0 : 12;
      rx_idle_pct = (p == 5) ? 0 : 12;
      if (p == 9) begin
        hold_reqs++;
      end

      repeat (PHASE_ITEMS) begin
        r    = $urandom_range(99);
        hall = HALL_W'($urandom_range(7));
        if (r < tick_pct && !(pr_guard && gen_stall >= STALL_LIMIT)) begin
          act = ACT_TICK;
          if (pr_guard) begin
            gen_stall++;
          end
        end else begin
          act = ACT_CAPTURE;
          gen_stall = 0;
          // keep the rotor order except for a share of broken sequences
          if (r < 88) begin
            pos  = fwd ? (pos + 1) % 6 : (pos + 5) % 6;
            hall = ROTATION[pos];
          end
        end
        offer(act, hall, '0);
      end
    end
    tx_idle_pct = 12;
    rx_idle_pct = 12;

    run_rows(HEAD_N, DIR_N);

    // Anything after the fault must read as forced off
    repeat (AFTER_FAULT) begin
      offer(action_e'($urandom_range(1)), HALL_W'($urandom_range(7)), '0);
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && drive_exp_q.size() == 0) begin
      $display("bldc_hall_commutator verification clean");
    end else begin
      $display("bldc_hall_commutator verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bhc_pkg.sv
sv/bhc_in_if.sv
sv/bhc_out_if.sv
sv/bldc_hall_commutator.sv
verif/bldc_hall_commutator_tb.sv
